// ===== hdl/fbd_pkg.sv =====
// fbd_pkg: shared types, widths and constants of the fractional baud divisor search
// used by fbd_divider, fractional_baud_divisor_search_top and fbd_checker
// depends on nothing

package fbd_pkg;

  // field widths
  localparam int unsigned BAUD_W    = 24;
  localparam int unsigned CLK_W     = 31;
  localparam int unsigned PCLK_W    = CLK_W - 2;
  localparam int unsigned DIVISOR_W = 17;
  localparam int unsigned MUL_W     = 4;
  localparam int unsigned PCT_W     = 8;
  localparam int unsigned STATUS_W  = 2;

  // fixed point layout of the candidate quotient
  localparam int unsigned FRAC_W     = 32;
  localparam int unsigned PCLK_SHIFT = 28;
  localparam int unsigned SUM_W      = MUL_W + 1;

  // shared serial divider
  localparam int unsigned NUM_W = PCLK_W + MUL_W + PCLK_SHIFT;   // 61
  localparam int unsigned DEN_W = 30;
  localparam int unsigned CNT_W = $clog2(NUM_W);

  // constants of the search
  localparam logic [MUL_W-1:0]     MUL_MAX      = 4'd15;
  localparam logic [DEN_W-1:0]     DIV_MAX      = 30'd65536;
  localparam logic [FRAC_W-1:0]    ERR_HALF     = 32'h8000_0000;
  localparam logic [FRAC_W-1:0]    ERR_INIT     = 32'hFFFF_FFFF;
  localparam logic [PCT_W-1:0]     PCT_SAT      = 8'd255;
  localparam logic [PCT_W-1:0]     ACCEPT_LIMIT = 8'd3;
  localparam logic [6:0]           PCT_SCALE    = 7'd100;
  localparam logic [CLK_W-1:0]     CLK_RESET    = 31'd100000000;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED = 2'd0,
    ST_HIGH_ERR = 2'd1,
    ST_NO_DIV   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CAND_LOAD,
    S_CAND_DIV,
    S_CAND_EVAL,
    S_FIN_LOAD,
    S_FIN_DIV,
    S_PCT_LOAD,
    S_PCT_DIV
  } state_t;

  // divider request and response
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== hdl/fractional_baud_divisor_search_top.sv =====
// fractional_baud_divisor_search_top: best divisor latch and fractional divider search
// depends on fbd_pkg and fbd_divider

// A request (start high while busy is low) carries a baud rate; the block answers with
// exactly one result, shown for a single cycle under out_valid, which the receiver must
// take as it comes. Internally one shared restoring divider is run again and again:
// each (mul, divadd) candidate goes through load, 61 quotient bits, done and check;
// up to 120 candidates are tried, and two more divisions form the actual baud and
// the percent error. An exact candidate ends the search early. A baud rate of zero
// skips the search and answers with status 2; when no divisor lands inside 1..65536
// status 2 comes after the full search.
// sys_clock_hz is written on the cfg channel while the block is idle; the peripheral
// clock is a quarter of it.

module fractional_baud_divisor_search_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          start,
  output logic                          busy,
  input  logic [fbd_pkg::BAUD_W-1:0]    in_baud_rate,
  // result channel
  output logic                          out_valid,
  output logic [fbd_pkg::DIVISOR_W-1:0] out_divisor,
  output logic [fbd_pkg::MUL_W-1:0]     out_mul_val,
  output logic [fbd_pkg::MUL_W-1:0]     out_divadd_val,
  output logic [fbd_pkg::PCT_W-1:0]     out_error_percent,
  output logic [fbd_pkg::STATUS_W-1:0]  out_status,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fbd_pkg::CLK_W-1:0]     cfg_sys_clock_hz
);

  fbd_pkg::state_t  state_r, state_nxt;
  fbd_pkg::div_req_t div_req;
  fbd_pkg::div_rsp_t div_rsp;

  // configuration
  logic [fbd_pkg::CLK_W-1:0]  clk_hz_r;
  logic [fbd_pkg::PCLK_W-1:0] pclk;

  // search state
  logic [fbd_pkg::BAUD_W-1:0]    baud_r, baud_nxt;
  logic [fbd_pkg::MUL_W-1:0]     mul_r, mul_nxt;
  logic [fbd_pkg::MUL_W-1:0]     add_r, add_nxt;
  logic [fbd_pkg::FRAC_W-1:0]    best_err_r, best_err_nxt;
  logic [fbd_pkg::DIVISOR_W-1:0] best_div_r, best_div_nxt;
  logic [fbd_pkg::MUL_W-1:0]     best_mul_r, best_mul_nxt;
  logic [fbd_pkg::MUL_W-1:0]     best_add_r, best_add_nxt;
  logic                          found_r, found_nxt;
  logic [fbd_pkg::DEN_W-1:0]     actual_r, actual_nxt;

  // result register
  logic                          out_valid_r, out_valid_nxt;
  logic [fbd_pkg::DIVISOR_W-1:0] out_div_r, out_div_nxt;
  logic [fbd_pkg::MUL_W-1:0]     out_mul_r, out_mul_nxt;
  logic [fbd_pkg::MUL_W-1:0]     out_add_r, out_add_nxt;
  logic [fbd_pkg::PCT_W-1:0]     out_pct_r, out_pct_nxt;
  fbd_pkg::status_t              out_status_r, out_status_nxt;

  // candidate operands
  logic [fbd_pkg::PCLK_W+fbd_pkg::MUL_W-1:0] cand_hi;
  logic [fbd_pkg::SUM_W-1:0]                 cand_sum;
  logic [fbd_pkg::BAUD_W+fbd_pkg::SUM_W-1:0] cand_den;

  // candidate check on the quotient
  logic [fbd_pkg::FRAC_W-1:0] err_raw, err_c;
  logic [fbd_pkg::DEN_W-1:0]  dv_c;
  logic                       round_up, in_range, better, exact, last_pair;

  // actual baud operands
  logic [fbd_pkg::PCLK_W-4+fbd_pkg::MUL_W-1:0]  fin_num;
  logic [fbd_pkg::SUM_W-1:0]                    fin_sum;
  logic [fbd_pkg::DIVISOR_W+fbd_pkg::SUM_W-1:0] fin_den;

  // percent error operands
  logic [fbd_pkg::DEN_W-1:0]   diff;
  logic [fbd_pkg::DEN_W+6:0]   pct_num;
  logic [fbd_pkg::PCT_W-1:0]   pct;

  assign pclk = clk_hz_r[fbd_pkg::CLK_W-1:2];

  // the search owns the clock value while it runs
  assign cfg_ready = (state_r == fbd_pkg::S_IDLE);
  assign busy      = (state_r != fbd_pkg::S_IDLE);

  // q = pclk * 2^28 * mul / (baud * (mul + divadd))
  assign cand_hi  = (fbd_pkg::PCLK_W + fbd_pkg::MUL_W)'(pclk) *
                    (fbd_pkg::PCLK_W + fbd_pkg::MUL_W)'(mul_r);
  assign cand_sum = fbd_pkg::SUM_W'(mul_r) + fbd_pkg::SUM_W'(add_r);
  assign cand_den = (fbd_pkg::BAUD_W + fbd_pkg::SUM_W)'(baud_r) *
                    (fbd_pkg::BAUD_W + fbd_pkg::SUM_W)'(cand_sum);

  // fraction above one half rounds the divisor up
  assign err_raw   = div_rsp.quot[fbd_pkg::FRAC_W-1:0];
  assign round_up  = err_raw > fbd_pkg::ERR_HALF;
  assign err_c     = round_up ? (fbd_pkg::FRAC_W'(0) - err_raw) : err_raw;
  assign dv_c      = {1'b0, div_rsp.quot[fbd_pkg::NUM_W-1:fbd_pkg::FRAC_W]} +
                     fbd_pkg::DEN_W'(round_up);
  assign in_range  = (dv_c != '0) && (dv_c <= fbd_pkg::DIV_MAX);
  assign better    = in_range && (err_c < best_err_r);
  assign exact     = better && (err_c == '0);
  assign last_pair = (mul_r == fbd_pkg::MUL_MAX) && (add_r == mul_r - 1'b1);

  // actual = (pclk / 16) * mul / (divisor * (mul + divadd))
  assign fin_num = (fbd_pkg::PCLK_W - 4 + fbd_pkg::MUL_W)'(pclk[fbd_pkg::PCLK_W-1:4]) *
                   (fbd_pkg::PCLK_W - 4 + fbd_pkg::MUL_W)'(best_mul_r);
  assign fin_sum = fbd_pkg::SUM_W'(best_mul_r) + fbd_pkg::SUM_W'(best_add_r);
  assign fin_den = (fbd_pkg::DIVISOR_W + fbd_pkg::SUM_W)'(best_div_r) *
                   (fbd_pkg::DIVISOR_W + fbd_pkg::SUM_W)'(fin_sum);

  // pct = |baud - actual| * 100 / baud
  assign diff    = (fbd_pkg::DEN_W'(baud_r) > actual_r) ?
                   (fbd_pkg::DEN_W'(baud_r) - actual_r) : (actual_r - fbd_pkg::DEN_W'(baud_r));
  assign pct_num = (fbd_pkg::DEN_W + 7)'(diff) * (fbd_pkg::DEN_W + 7)'(fbd_pkg::PCT_SCALE);
  assign pct     = (div_rsp.quot > fbd_pkg::NUM_W'(fbd_pkg::PCT_SAT)) ?
                   fbd_pkg::PCT_SAT : div_rsp.quot[fbd_pkg::PCT_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fbd_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = (in_baud_rate == '0) ? fbd_pkg::S_FIN_LOAD : fbd_pkg::S_CAND_LOAD;
        end
      end
      fbd_pkg::S_CAND_LOAD: state_nxt = fbd_pkg::S_CAND_DIV;
      fbd_pkg::S_CAND_DIV: begin
        if (div_rsp.done) state_nxt = fbd_pkg::S_CAND_EVAL;
      end
      fbd_pkg::S_CAND_EVAL: begin
        if (exact || last_pair) state_nxt = fbd_pkg::S_FIN_LOAD;
        else                    state_nxt = fbd_pkg::S_CAND_LOAD;
      end
      fbd_pkg::S_FIN_LOAD: begin
        state_nxt = found_r ? fbd_pkg::S_FIN_DIV : fbd_pkg::S_IDLE;
      end
      fbd_pkg::S_FIN_DIV: begin
        if (div_rsp.done) state_nxt = fbd_pkg::S_PCT_LOAD;
      end
      fbd_pkg::S_PCT_LOAD: state_nxt = fbd_pkg::S_PCT_DIV;
      fbd_pkg::S_PCT_DIV: begin
        if (div_rsp.done) state_nxt = fbd_pkg::S_IDLE;
      end
      default: state_nxt = fbd_pkg::S_IDLE;
    endcase
  end

  // datapath and divider control
  always_comb begin
    div_req        = '0;
    baud_nxt       = baud_r;
    mul_nxt        = mul_r;
    add_nxt        = add_r;
    best_err_nxt   = best_err_r;
    best_div_nxt   = best_div_r;
    best_mul_nxt   = best_mul_r;
    best_add_nxt   = best_add_r;
    found_nxt      = found_r;
    actual_nxt     = actual_r;
    out_valid_nxt  = 1'b0;
    out_div_nxt    = out_div_r;
    out_mul_nxt    = out_mul_r;
    out_add_nxt    = out_add_r;
    out_pct_nxt    = out_pct_r;
    out_status_nxt = out_status_r;
    case (state_r)
      fbd_pkg::S_IDLE: begin
        if (start) begin
          baud_nxt     = in_baud_rate;
          mul_nxt      = fbd_pkg::MUL_W'(1);
          add_nxt      = '0;
          best_err_nxt = fbd_pkg::ERR_INIT;
          found_nxt    = 1'b0;
        end
      end
      fbd_pkg::S_CAND_LOAD: begin
        div_req.start = 1'b1;
        div_req.num   = {cand_hi, fbd_pkg::PCLK_SHIFT'(0)};
        div_req.den   = fbd_pkg::DEN_W'(cand_den);
      end
      fbd_pkg::S_CAND_EVAL: begin
        if (better) begin
          best_err_nxt = err_c;
          best_div_nxt = dv_c[fbd_pkg::DIVISOR_W-1:0];
          best_mul_nxt = mul_r;
          best_add_nxt = add_r;
          found_nxt    = 1'b1;
        end
        // step divadd, wrap into the next multiplier
        if (add_r == mul_r - 1'b1) begin
          mul_nxt = mul_r + 1'b1;
          add_nxt = '0;
        end else begin
          add_nxt = add_r + 1'b1;
        end
      end
      fbd_pkg::S_FIN_LOAD: begin
        if (found_r) begin
          div_req.start = 1'b1;
          div_req.num   = fbd_pkg::NUM_W'(fin_num);
          div_req.den   = fbd_pkg::DEN_W'(fin_den);
        end else begin
          // nothing in range
          out_valid_nxt  = 1'b1;
          out_div_nxt    = '0;
          out_mul_nxt    = '0;
          out_add_nxt    = '0;
          out_pct_nxt    = fbd_pkg::PCT_SAT;
          out_status_nxt = fbd_pkg::ST_NO_DIV;
        end
      end
      fbd_pkg::S_FIN_DIV: begin
        if (div_rsp.done) actual_nxt = div_rsp.quot[fbd_pkg::DEN_W-1:0];
      end
      fbd_pkg::S_PCT_LOAD: begin
        div_req.start = 1'b1;
        div_req.num   = fbd_pkg::NUM_W'(pct_num);
        div_req.den   = fbd_pkg::DEN_W'(baud_r);
      end
      fbd_pkg::S_PCT_DIV: begin
        if (div_rsp.done) begin
          out_valid_nxt  = 1'b1;
          out_div_nxt    = best_div_r;
          out_mul_nxt    = best_mul_r;
          out_add_nxt    = best_add_r;
          out_pct_nxt    = pct;
          out_status_nxt = (pct < fbd_pkg::ACCEPT_LIMIT) ? fbd_pkg::ST_ACCEPTED
                                                         : fbd_pkg::ST_HIGH_ERR;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fbd_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      clk_hz_r    <= fbd_pkg::CLK_RESET;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
      if (cfg_valid && cfg_ready) clk_hz_r <= cfg_sys_clock_hz;
    end
    baud_r       <= baud_nxt;
    mul_r        <= mul_nxt;
    add_r        <= add_nxt;
    best_err_r   <= best_err_nxt;
    best_div_r   <= best_div_nxt;
    best_mul_r   <= best_mul_nxt;
    best_add_r   <= best_add_nxt;
    actual_r     <= actual_nxt;
    out_div_r    <= out_div_nxt;
    out_mul_r    <= out_mul_nxt;
    out_add_r    <= out_add_nxt;
    out_pct_r    <= out_pct_nxt;
    out_status_r <= out_status_nxt;
  end

  fbd_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_valid         = out_valid_r;
  assign out_divisor       = out_div_r;
  assign out_mul_val       = out_mul_r;
  assign out_divadd_val    = out_add_r;
  assign out_error_percent = out_pct_r;
  assign out_status        = out_status_r;

endmodule

// ===== hdl/fbd_divider.sv =====
// fbd_divider: restoring radix-2 divider, one quotient bit per cycle
// depends on fbd_pkg (widths, div_req_t, div_rsp_t)

module fbd_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  fbd_pkg::div_req_t req,
  output fbd_pkg::div_rsp_t rsp
);

  logic                      run_r, run_nxt;
  logic                      done_r, done_nxt;
  logic [fbd_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [fbd_pkg::NUM_W-1:0] num_r, num_nxt;
  logic [fbd_pkg::DEN_W-1:0] den_r, den_nxt;
  logic [fbd_pkg::DEN_W-1:0] rem_r, rem_nxt;
  logic [fbd_pkg::DEN_W:0]   rem_sh;
  logic                      fits;

  assign rem_sh = {rem_r, num_r[fbd_pkg::NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      run_nxt = 1'b1;
      cnt_nxt = fbd_pkg::CNT_W'(fbd_pkg::NUM_W - 1);
      num_nxt = req.num;
      den_nxt = req.den;
      rem_nxt = '0;
    end else if (run_r) begin
      // shift in next dividend bit, subtract if it fits
      if (fits) begin
        rem_nxt = fbd_pkg::DEN_W'(rem_sh - {1'b0, den_r});
      end else begin
        rem_nxt = rem_sh[fbd_pkg::DEN_W-1:0];
      end
      num_nxt = {num_r[fbd_pkg::NUM_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = num_r;

endmodule

// ===== hdl/fbd_checker.sv =====
// fbd_checker: port level checks of the divisor search, bound to the top level
// depends on fbd_pkg and fractional_baud_divisor_search_top

module fbd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [fbd_pkg::DIVISOR_W-1:0] out_divisor,
  input logic [fbd_pkg::MUL_W-1:0]     out_mul_val,
  input logic [fbd_pkg::PCT_W-1:0]     out_error_percent,
  input logic [fbd_pkg::STATUS_W-1:0]  out_status
);

  // an accepted request always makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request accepted but block not busy");

  // a result only comes once the search is over
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // no divisor found reports the fixed fallback fields
  a_no_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == fbd_pkg::ST_NO_DIV) |->
      (out_divisor == '0) && (out_mul_val == '0) &&
      (out_error_percent == fbd_pkg::PCT_SAT))
    else $error("no divisor result has wrong fields");

  // an accepted result carries a real pair and a small error
  a_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == fbd_pkg::ST_ACCEPTED) |->
      (out_error_percent < fbd_pkg::ACCEPT_LIMIT) && (out_divisor != '0) &&
      (out_mul_val != '0))
    else $error("accepted result out of bounds");

endmodule

bind fractional_baud_divisor_search_top fbd_checker u_fbd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_divisor       (out_divisor),
  .out_mul_val       (out_mul_val),
  .out_error_percent (out_error_percent),
  .out_status        (out_status)
);
